// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// File: rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Types and codes shared by the polygon collision and containment block.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam logic [1:0] OP_APPEND_A = 2'd0;
  localparam logic [1:0] OP_APPEND_B = 2'd1;
  localparam logic [1:0] OP_EVAL     = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FEW      = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Cross product kinds issued per edge pair.
  localparam logic [1:0] CK_A_B1 = 2'd0;  // edge a against b1
  localparam logic [1:0] CK_A_B2 = 2'd1;  // edge a against b2
  localparam logic [1:0] CK_B_A1 = 2'd2;  // edge b against a1
  localparam logic [1:0] CK_B_A2 = 2'd3;  // edge b against a2

  localparam int unsigned PointBits = 32;

  // x sits in bits 15..0, y in bits 31..16.
  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic       collide;
    logic       contain;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       neg;
    logic       zero;
  } cross_res_t;

endpackage

// File: rtl/core/pcc_ram.sv
// ----------------------------------------------------------------------------
// pcc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/pcc_cross.sv
// ----------------------------------------------------------------------------
// pcc_cross
// Pipelined cross product sign unit: (q-p) x (p-r); differences and products are registered.
// ----------------------------------------------------------------------------
module pcc_cross (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [1:0]          kind_i,
  input  pcc_pkg::point_t     p_i,
  input  pcc_pkg::point_t     q_i,
  input  pcc_pkg::point_t     r_i,
  output pcc_pkg::cross_res_t res_o
);
  import pcc_pkg::*;

  logic               v1_q, v2_q;
  logic [1:0]         k1_q, k2_q;
  logic signed [16:0] dx_q, dy_q, py_q, px_q;
  logic signed [33:0] m0_q, m1_q;
  logic signed [34:0] diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Stage one: coordinate differences. Stage two: the two products.
  always_ff @(posedge clk_i) begin
    k1_q <= kind_i;
    dx_q <= 17'(q_i.x) - 17'(p_i.x);
    dy_q <= 17'(q_i.y) - 17'(p_i.y);
    py_q <= 17'(p_i.y) - 17'(r_i.y);
    px_q <= 17'(p_i.x) - 17'(r_i.x);
    k2_q <= k1_q;
    m0_q <= 34'(dx_q) * 34'(py_q);
    m1_q <= 34'(dy_q) * 34'(px_q);
  end

  assign diff = 35'(m0_q) - 35'(m1_q);

  assign res_o = '{valid: v2_q, kind: k2_q, neg: diff[34], zero: (diff == '0)};

endmodule

// File: rtl/core/polygon_collision_containment.sv
// ----------------------------------------------------------------------------
// polygon_collision_containment
// Loads two closed polygons, then tests edge crossings and containment.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | sink      | in_valid_i / in_stall_o | in_item_i  (opcode, x, y)
//  out     | source    | out_valid_o/out_stall_i | out_item_o (collide,
//          |           |                        |   contain, status)
//
//  Append beats are taken back to back.
//  An evaluate beat stalls the input until its verdict is loaded into the
//  output register, going straight to the done state when a polygon has
//  under three vertices. Otherwise each edge pair walks RD0 and RD1 (RAM
//  reads), RD2 (capture), ISSUE (all four kinds into the shared cross product
//  pipeline), WAIT (pipeline drain) and PAIR (decision). The done state holds
//  for as long as an earlier result still waits stalled in the output register.
//  The result leaves from an output register.
//  Reset clears counts, overflow flag and handshake state; RAM contents
//  stay undefined until written. A stalled result holds, and new appends
//  are still taken while it waits.
//
module polygon_collision_containment #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pcc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pcc_pkg::out_item_t out_item_o
);
  import pcc_pkg::*;

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD0   = 3'd1;
  localparam logic [2:0] ST_RD1   = 3'd2;
  localparam logic [2:0] ST_RD2   = 3'd3;
  localparam logic [2:0] ST_ISSUE = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_PAIR  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] na_q, na_d, nb_q, nb_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, i_next, j_next;
  logic [1:0]    k_q, k_d;
  logic          first_q, first_d;
  logic          out_valid_q, out_valid_d;

  logic          collide_q, collide_d, contain_q, contain_d;
  logic [1:0]    status_q, status_d;
  logic          prev_neg_q, prev_neg_d, prev_zero_q, prev_zero_d;
  point_t        a1_q, a1_d, a2_q, a2_d, b1_q, b1_d, b2_q, b2_d;
  logic [3:0]    sneg_q, szero_q;
  out_item_t     out_item_q;

  logic          in_accept, load_out, we_a, we_b;
  logic          last_i, last_j, na_full, nb_full, few;
  logic [IW-1:0] raddr_a, raddr_b;
  logic [PointBits-1:0] rdata_a, rdata_b, wdata;

  logic          cr_valid;
  point_t        cr_p, cr_q, cr_r;
  cross_res_t    cr_res;

  logic          s12_neg, s34_neg, s12_zero, shared_pt, hit, flip;

  // --------------------------------------------------------------------------
  // Vertex stores
  // --------------------------------------------------------------------------
  assign wdata = PointBits'(point_t'{y: in_item_i.y_coord, x: in_item_i.x_coord});

  pcc_ram #(.WIDTH(PointBits), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (na_q[IW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  pcc_ram #(.WIDTH(PointBits), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (nb_q[IW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Edge i closes back to vertex 0 after the last vertex.
  assign last_i = (CW'(i_q) == na_q - CW'(1));
  assign last_j = (CW'(j_q) == nb_q - CW'(1));
  assign i_next = last_i ? '0 : i_q + IW'(1);
  assign j_next = last_j ? '0 : j_q + IW'(1);

  // First read cycle fetches the edge start, the second the edge end.
  assign raddr_a = (state_q == ST_RD1) ? i_next : i_q;
  assign raddr_b = (state_q == ST_RD1) ? j_next : j_q;

  assign na_full = (na_q == CW'(MAX_VERTICES));
  assign nb_full = (nb_q == CW'(MAX_VERTICES));
  assign few     = (na_q < CW'(3)) || (nb_q < CW'(3));

  // --------------------------------------------------------------------------
  // Shared cross product pipeline
  // --------------------------------------------------------------------------
  always_comb begin
    cr_p = a1_q;
    cr_q = a2_q;
    cr_r = b1_q;
    unique case (k_q)
      CK_A_B1: cr_r = b1_q;
      CK_A_B2: cr_r = b2_q;
      CK_B_A1: begin
        cr_p = b1_q;
        cr_q = b2_q;
        cr_r = a1_q;
      end
      CK_B_A2: begin
        cr_p = b1_q;
        cr_q = b2_q;
        cr_r = a2_q;
      end
      default: cr_r = b1_q;
    endcase
  end

  pcc_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cr_valid),
    .kind_i  (k_q),
    .p_i     (cr_p),
    .q_i     (cr_q),
    .r_i     (cr_r),
    .res_o   (cr_res)
  );

  // --------------------------------------------------------------------------
  // Pair decision
  // --------------------------------------------------------------------------
  // Product of signs is negative only when both are nonzero and differ.
  assign s12_neg   = !szero_q[CK_A_B1] && !szero_q[CK_A_B2] &&
                     (sneg_q[CK_A_B1] ^ sneg_q[CK_A_B2]);
  assign s34_neg   = !szero_q[CK_B_A1] && !szero_q[CK_B_A2] &&
                     (sneg_q[CK_B_A1] ^ sneg_q[CK_B_A2]);
  assign s12_zero  = szero_q[CK_A_B1] || szero_q[CK_A_B2];
  assign shared_pt = (a1_q == b1_q) || (a1_q == b2_q) ||
                     (a2_q == b1_q) || (a2_q == b2_q);
  assign hit       = (s12_neg && s34_neg) || (s12_zero && shared_pt);

  // The containment walk sees the edge-a-versus-b1 product of each pair in
  // order; a zero on either side breaks the chain, the first pair has none.
  assign flip = !first_q && !prev_zero_q && !szero_q[CK_A_B1] &&
                (prev_neg_q ^ sneg_q[CK_A_B1]);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    na_d        = na_q;
    nb_d        = nb_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    first_d     = first_q;
    collide_d   = collide_q;
    contain_d   = contain_q;
    status_d    = status_q;
    prev_neg_d  = prev_neg_q;
    prev_zero_d = prev_zero_q;
    a1_d        = a1_q;
    a2_d        = a2_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    we_a        = 1'b0;
    we_b        = 1'b0;
    cr_valid    = 1'b0;
    load_out    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_item_i.opcode)
            OP_APPEND_A: begin
              if (na_full) begin
                ovf_d = 1'b1;
              end else begin
                we_a = 1'b1;
                na_d = na_q + CW'(1);
              end
            end
            OP_APPEND_B: begin
              if (nb_full) begin
                ovf_d = 1'b1;
              end else begin
                we_b = 1'b1;
                nb_d = nb_q + CW'(1);
              end
            end
            OP_EVAL: begin
              i_d       = '0;
              j_d       = '0;
              first_d   = 1'b1;
              collide_d = 1'b0;
              contain_d = 1'b1;
              status_d  = ovf_q ? STATUS_OVERFLOW : STATUS_OK;
              if (few) begin
                contain_d = 1'b0;
                status_d  = STATUS_FEW;
                state_d   = ST_DONE;
              end else begin
                state_d   = ST_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD0: state_d = ST_RD1;
      ST_RD1: begin
        a1_d    = point_t'(rdata_a);
        b1_d    = point_t'(rdata_b);
        state_d = ST_RD2;
      end
      ST_RD2: begin
        a2_d    = point_t'(rdata_a);
        b2_d    = point_t'(rdata_b);
        k_d     = CK_A_B1;
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        cr_valid = 1'b1;
        k_d      = k_q + 2'd1;
        if (k_q == CK_B_A2) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (cr_res.valid && (cr_res.kind == CK_B_A2)) begin
          state_d = ST_PAIR;
        end
      end
      ST_PAIR: begin
        collide_d   = collide_q | hit;
        contain_d   = contain_q & !flip;
        prev_neg_d  = sneg_q[CK_A_B1];
        prev_zero_d = szero_q[CK_A_B1];
        first_d     = 1'b0;
        j_d         = j_next;
        state_d     = ST_RD0;
        if (last_j) begin
          i_d = i_next;
          if (last_i) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // Hold until the output register is free, then clear both polygons.
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          na_d     = '0;
          nb_d     = '0;
          ovf_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end
    endcase

    out_valid_d = load_out | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      na_q        <= '0;
      nb_q        <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= CK_A_B1;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    collide_q   <= collide_d;
    contain_q   <= contain_d;
    status_q    <= status_d;
    prev_neg_q  <= prev_neg_d;
    prev_zero_q <= prev_zero_d;
    a1_q        <= a1_d;
    a2_q        <= a2_d;
    b1_q        <= b1_d;
    b2_q        <= b2_d;
    if (cr_res.valid) begin
      sneg_q[cr_res.kind]  <= cr_res.neg;
      szero_q[cr_res.kind] <= cr_res.zero;
    end
    if (load_out) begin
      out_item_q <= '{collide: collide_q, contain: contain_q, status: status_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/core/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port level checks for the polygon collision and containment block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input pcc_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pcc_pkg::out_item_t out_item_o
);
  import pcc_pkg::*;

  // A stalled result beat stays offered.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result beat dropped while stalled")

  // A new result only appears at the end of an evaluate, while input stalls.
  `ASSERT_RST(a_out_after_eval, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result without evaluate")

  // An accepted evaluate beat stalls the input in the next cycle.
  `ASSERT_RST(a_eval_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_item_i.opcode == OP_EVAL) |=> in_stall_o, "evaluate did not stall input")

  // Any other beat leaves the input open.
  `ASSERT_RST(a_append_open, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_item_i.opcode != OP_EVAL) |=> !in_stall_o, "append stalled input")

  // Reset empties the output register.
  `ASSERT_ALWAYS(a_reset_clear, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind polygon_collision_containment pcc_checker u_pcc_checker (.*);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for polygon_collision_containment. Streams vertex and
// evaluate beats, predicts every verdict in-bench, compares field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int unsigned MAX_VERTS    = 16;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          RANDOM_BEATS = 1170;
  localparam int          HOLD_CYCLES  = 600;
  localparam out_item_t   FEW_VERDICT  = {1'b0, 1'b0, STATUS_FEW};

  // One row of the directed table: a beat, how often to repeat it, and an
  // optional verdict typed in by hand for evaluate rows.
  typedef struct packed {
    in_item_t   item;
    logic [4:0] reps;
    logic       fixed;
    out_item_t  res;
  } drill_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  // Hand-typed verdict travelling alongside the current input beat.
  logic      item_fixed;
  out_item_t item_fixed_res;

  // Predicted polygon state.
  point_t      poly_a [MAX_VERTS];
  point_t      poly_b [MAX_VERTS];
  int unsigned len_a;
  int unsigned len_b;
  bit          dropped;

  out_item_t verdict_q [$];
  int        fault_count;
  int        beats_sent;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_ask;
  int        hold_left;

  polygon_collision_containment #(
    .MAX_VERTICES(MAX_VERTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Give up after a fixed, generous time; a healthy run ends far sooner.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Verdict predictor
  // --------------------------------------------------------------------------

  function automatic int sign_of(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // Cross product of edge (a,b) with point p, exact in 64 bits.
  function automatic longint cross_of(point_t a, point_t b, point_t p);
    longint ax, ay, bx, by, px, py;
    ax = $signed(a.x);
    ay = $signed(a.y);
    bx = $signed(b.x);
    by = $signed(b.y);
    px = $signed(p.x);
    py = $signed(p.y);
    return (bx - ax) * (ay - py) - (by - ay) * (ax - px);
  endfunction

  // Proper crossing, or a collinear/touching case that shares an endpoint.
  function automatic bit edges_meet(point_t a1, point_t a2, point_t b1, point_t b2);
    int s12, s34;
    s12 = sign_of(cross_of(a1, a2, b1)) * sign_of(cross_of(a1, a2, b2));
    s34 = sign_of(cross_of(b1, b2, a1)) * sign_of(cross_of(b1, b2, a2));
    if (s12 < 0 && s34 < 0) return 1'b1;
    if (s12 == 0) return (a1 == b1) || (a1 == b2) || (a2 == b1) || (a2 == b2);
    return 1'b0;
  endfunction

  function automatic out_item_t judge_polygons();
    out_item_t   r;
    longint      prev, c;
    bit          hit;
    int unsigned i, j;
    point_t      a1, a2;
    r = '0;
    if (len_a < 3 || len_b < 3) begin
      r.status = STATUS_FEW;
    end else begin
      r.status = dropped ? STATUS_OVERFLOW : STATUS_OK;
      hit = 1'b0;
      for (i = 0; i < len_a && !hit; i++) begin
        a1 = poly_a[i];
        a2 = poly_a[(i + 1) % len_a];
        for (j = 0; j < len_b && !hit; j++)
          hit = edges_meet(a1, a2, poly_b[j], poly_b[(j + 1) % len_b]);
      end
      r.collide = hit;
      // Sign walk: a strict flip clears contain, a zero restarts the walk.
      r.contain = 1'b1;
      prev = cross_of(poly_a[0], poly_a[1], poly_b[0]);
      for (i = 0; i < len_a && r.contain; i++) begin
        a1 = poly_a[i];
        a2 = poly_a[(i + 1) % len_a];
        for (j = 0; j < len_b && r.contain; j++) begin
          c = cross_of(a1, a2, poly_b[j]);
          if (sign_of(c) * sign_of(prev) < 0) r.contain = 1'b0;
          else prev = c;
        end
      end
    end
    return r;
  endfunction

  // Advance the predicted state by one accepted beat; returns 1 on a verdict.
  function automatic bit step_polygons(in_item_t b, output out_item_t r);
    point_t p;
    p.x = b.x_coord;
    p.y = b.y_coord;
    r = '0;
    case (b.opcode)
      OP_APPEND_A: begin
        if (len_a >= MAX_VERTS) dropped = 1'b1;
        else begin
          poly_a[len_a] = p;
          len_a++;
        end
        return 1'b0;
      end
      OP_APPEND_B: begin
        if (len_b >= MAX_VERTS) dropped = 1'b1;
        else begin
          poly_b[len_b] = p;
          len_b++;
        end
        return 1'b0;
      end
      OP_EVAL: begin
        r = judge_polygons();
        len_a = 0;
        len_b = 0;
        dropped = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    out_item_t want, predicted;
    // Check the outgoing beat first; it always belongs to an older evaluate.
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict collide=%0b contain=%0b status=%0d",
                 $time, out_item_o.collide, out_item_o.contain, out_item_o.status);
        fault_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_item_o.collide !== want.collide || out_item_o.contain !== want.contain ||
            out_item_o.status !== want.status) begin
          $display("%0t: verdict mismatch expected collide=%0b contain=%0b status=%0d",
                   $time, want.collide, want.contain, want.status);
          $display("%0t:                  actual   collide=%0b contain=%0b status=%0d",
                   $time, out_item_o.collide, out_item_o.contain, out_item_o.status);
          fault_count++;
        end
      end
    end
    // Predict on every accepted input beat; a hand-typed verdict wins.
    if (rst_ni && in_valid_i && !in_stall_o)
      if (step_polygons(in_item_i, predicted))
        verdict_q.push_back(item_fixed ? item_fixed_res : predicted);
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (int'($urandom_range(99, 0)) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers; every task is entered and left at a falling edge
  // --------------------------------------------------------------------------

  // Idle at random, then hold the beat until it is taken.
  task automatic offer(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
                       bit fixed, out_item_t res);
    in_item_t beat;
    beat.opcode  = op;
    beat.x_coord = x;
    beat.y_coord = y;
    while (int'($urandom_range(99, 0)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_item_i      <= beat;
    item_fixed     <= fixed;
    item_fixed_res <= res;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  // Drop valid and wait for every outstanding verdict.
  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_eval();
    point_t rp;
    rp = $urandom;
    offer(OP_EVAL, rp.x, rp.y, 1'b0, '0);
  endtask

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic logic signed [15:0] clip_q88(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic point_t make_point(int x, int y);
    point_t p;
    p.x = clip_q88(x);
    p.y = clip_q88(y);
    return p;
  endfunction

  // Mostly small polygons, a few large ones, a few that overflow.
  function automatic int pick_count();
    int r;
    r = $urandom_range(99, 0);
    if (r < 85) return $urandom_range(6, 3);
    if (r < 95) return $urandom_range(16, 7);
    return $urandom_range(19, 17);
  endfunction

  // Load a pair of polygons in random interleaving, then evaluate.
  task automatic send_polygon_pair(bit small_only);
    point_t pa [20];
    point_t pb [20];
    int     na, nb, ia, ib, geo, cx, cy, ra, rb, bx, by, k;
    na  = small_only ? 3 : pick_count();
    nb  = small_only ? 3 : pick_count();
    geo = $urandom_range(9, 0);
    cx  = rand_between(-12000, 12000);
    cy  = rand_between(-12000, 12000);
    ra  = rand_between(64, 4096);
    if (geo == 0) begin
      // Full range: every coordinate bit toggles.
      for (k = 0; k < na; k++) pa[k] = $urandom;
      for (k = 0; k < nb; k++) pb[k] = $urandom;
    end else if (geo <= 2) begin
      // Coarse grid: plenty of shared points and collinear edges.
      for (k = 0; k < na; k++)
        pa[k] = make_point(256 * rand_between(-4, 4), 256 * rand_between(-4, 4));
      for (k = 0; k < nb; k++)
        pb[k] = make_point(256 * rand_between(-4, 4), 256 * rand_between(-4, 4));
    end else if (geo <= 5) begin
      // Box A in either winding, B inside it or straddling its edges.
      na = 4;
      pa[0] = make_point(cx - ra, cy - ra);
      pa[1] = make_point(cx + ra, cy - ra);
      pa[2] = make_point(cx + ra, cy + ra);
      pa[3] = make_point(cx - ra, cy + ra);
      if ($urandom_range(1, 0) == 1) {pa[1], pa[3]} = {pa[3], pa[1]};
      rb = ($urandom_range(1, 0) == 1) ? ra / 2 : ra + ra / 2;
      for (k = 0; k < nb; k++)
        pb[k] = make_point(cx + rand_between(-rb, rb), cy + rand_between(-rb, rb));
    end else begin
      // Two nearby point clouds, sometimes sharing a vertex.
      for (k = 0; k < na; k++)
        pa[k] = make_point(cx + rand_between(-ra, ra), cy + rand_between(-ra, ra));
      bx = cx + rand_between(-2 * ra, 2 * ra);
      by = cy + rand_between(-2 * ra, 2 * ra);
      rb = rand_between(16, ra);
      for (k = 0; k < nb; k++)
        pb[k] = make_point(bx + rand_between(-rb, rb), by + rand_between(-rb, rb));
      if ($urandom_range(3, 0) == 0) pb[0] = pa[$urandom_range(na - 1, 0)];
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib == nb || (ia < na && $urandom_range(1, 0) == 1)) begin
        offer(OP_APPEND_A, pa[ia].x, pa[ia].y, 1'b0, '0);
        ia++;
      end else begin
        offer(OP_APPEND_B, pb[ib].x, pb[ib].y, 1'b0, '0);
        ib++;
      end
    end
    send_eval();
  endtask

  // Short burst of arbitrary beats, unused opcode included.
  task automatic send_noise();
    point_t     rp;
    logic [1:0] op;
    int         n, k;
    n = rand_between(1, 8);
    for (k = 0; k < n; k++) begin
      rp = $urandom;
      op = 2'($urandom_range(3, 0));
      offer(op, rp.x, rp.y, 1'b0, '0);
    end
  endtask

  function automatic drill_row_t drill_row(logic [1:0] op, int x, int y, int reps,
                                           bit fixed, out_item_t res);
    drill_row_t r;
    r.item.opcode  = op;
    r.item.x_coord = x[15:0];
    r.item.y_coord = y[15:0];
    r.reps         = reps[4:0];
    r.fixed        = fixed;
    r.res          = res;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    drill_row_t drill_q [$];
    int         phase;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    item_fixed     = 1'b0;
    item_fixed_res = '0;
    out_stall_i    = 1'b0;
    fault_count    = 0;
    beats_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ask       = 1'b0;
    hold_left      = 0;
    len_a          = 0;
    len_b          = 0;
    dropped        = 1'b0;

    // Evaluate straight out of reset: both polygons empty.
    drill_q.push_back(drill_row(OP_EVAL, 0, 0, 1, 1'b1, FEW_VERDICT));
    // Full-scale triangle around a small one.
    drill_q.push_back(drill_row(OP_APPEND_A, -32768, -32768, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_A, 32767, -32768, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_A, 0, 32767, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, -256, -256, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, 256, -256, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, 0, 256, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_EVAL, 0, 0, 1, 1'b0, '0));
    // Shared corner, with a B vertex lying on A's long edge.
    drill_q.push_back(drill_row(OP_APPEND_A, 0, 0, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_A, 512, 0, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_A, 0, 512, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, 512, 0, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, 1024, 512, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, 256, 256, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_EVAL, 0, 0, 1, 1'b0, '0));
    // Unused opcode with all coordinate bits set: no effect, no verdict.
    drill_q.push_back(drill_row(OP_UNUSED, -1, -1, 1, 1'b0, '0));
    // Overfill A: the seventeenth append is dropped and flagged.
    drill_q.push_back(drill_row(OP_APPEND_A, 32767, -32768, 17, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, -512, 0, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, 512, 0, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, 0, 512, 1, 1'b0, '0));
    drill_q.push_back(drill_row(OP_EVAL, 0, 0, 1, 1'b0, '0));
    // Too few vertices in A outranks an overflowed B.
    drill_q.push_back(drill_row(OP_APPEND_A, -32768, 32767, 2, 1'b0, '0));
    drill_q.push_back(drill_row(OP_APPEND_B, 0, 0, 17, 1'b0, '0));
    drill_q.push_back(drill_row(OP_EVAL, 0, 0, 1, 1'b1, FEW_VERDICT));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table with no idling on either side.
    foreach (drill_q[k])
      repeat (drill_q[k].reps)
        offer(drill_q[k].item.opcode, drill_q[k].item.x_coord, drill_q[k].item.y_coord,
              drill_q[k].fixed, drill_q[k].res);
    drain_verdicts();

    // Hold the receiver off while evaluates pile up, so the output register
    // fills and the input stalls; then pause until everything has drained.
    hold_ask = 1'b1;
    repeat (4) send_polygon_pair(1'b1);
    drain_verdicts();

    // Random part in four idling phases.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      phase = beats_sent * 4 / RANDOM_BEATS;
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase
      if ($urandom_range(99, 0) < 80) send_polygon_pair(1'b0);
      else send_noise();
    end

    drain_verdicts();
    repeat (40) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
